// File: design/bbcv_pkg.sv
// Shared constants for the buck-boost CV/CC loop: duty limits, compensator
// coefficients, register indexes, mode codes and multiplier operand widths.
// No dependencies.
package bbcv_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_VOUT_SET_REF       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOUT_SOFTSTART_REF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IOUT_TARGET        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCK_MAX_DUTY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_MAX_DUTY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD         = 3'd7;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_BUCK  = 2'd1;
  localparam logic [1:0] MODE_BOOST = 2'd2;
  localparam logic [1:0] MODE_MIX   = 2'd3;

  localparam logic [15:0] MIN_BUCK_DUTY     = 16'd1360;
  localparam logic [15:0] BOOST_DUTY_FLOOR  = 16'd1360;
  localparam logic [15:0] BUCK_FIXED_DUTY   = 16'd25568;
  localparam logic [15:0] BUCK_MIX_DUTY     = 16'd21760;
  localparam logic [15:0] BOOST_FIXED_DUTY  = 16'd1632;
  localparam logic [15:0] INTEGRAL_LIMIT    = 16'd4095;

  localparam logic [15:0] RST_BUCK_MAX_DUTY  = 16'd25568;
  localparam logic [15:0] RST_BOOST_MAX_DUTY = 16'd25568;
  localparam logic [15:0] RST_CAL_GAIN       = 16'd4096;
  localparam logic [15:0] RST_PWM_PERIOD     = 16'd27200;

  // Shared multiplier: 18-bit signed error (or zero-extended sample) times
  // 17-bit signed coefficient (or zero-extended gain).
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned COEF_W  = MUL_B_W;

  localparam logic signed [COEF_W-1:0] COEF_BUCK [3] =
    '{17'sd5271, -17'sd10363, 17'sd5093};
  localparam logic signed [COEF_W-1:0] COEF_BOOST [3] =
    '{17'sd8044, -17'sd15813, 17'sd7772};

endpackage

// File: design/bbcv_mul.sv
// Shared signed multiplier with a registered product.
// Operand widths come from bbcv_pkg defaults.
module bbcv_mul #(
  parameter int unsigned AW = bbcv_pkg::MUL_A_W,
  parameter int unsigned BW = bbcv_pkg::MUL_B_W
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// File: design/buck_boost_cv_cc_loop_unit.sv
// Cascaded CV/CC loop for a buck-boost stage: PID current loop, 2p2z voltage loop.
// A request passes S_MULV, S_VCAL, S_LIM, S_ERR, S_MAC0-2, S_ACC, S_DUTY and S_OUT,
// which waits for a free output; no new request is taken until then. The sequencer
// steps one shared multiplier through the calibration product and the three
// compensator taps. Reset (rst_ni, asynchronous, active low) clears loop history,
// held duties and loads register defaults. Depends on bbcv_pkg and bbcv_mul.
module buck_boost_cv_cc_loop_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bbcv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbcv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [11:0]                        vout_sample_i,
  input  logic [11:0]                        iout_sample_i,
  input  logic                               soft_start_i,
  input  logic [1:0]                         converter_mode_i,
  input  logic                               mode_change_i,
  input  logic                               pwm_enable_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        buck_compare_o,
  output logic [14:0]                        adc_trigger_compare_o,
  output logic [15:0]                        boost_compare_o,
  output logic                               constant_current_o
);
  import bbcv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MULV, S_VCAL, S_LIM, S_ERR, S_MAC0, S_MAC1, S_MAC2, S_ACC,
    S_DUTY, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0]        vout_set_ref_q, vout_softstart_ref_q;
  logic [11:0]        iout_target_q;
  logic [15:0]        buck_max_duty_q, boost_max_duty_q, cal_gain_q, pwm_period_q;
  logic signed [12:0] cal_offset_q;

  // latched request
  logic [11:0] vs_q, is_q;
  logic        ss_q, mchg_q, pwm_en_q;
  logic [1:0]  mode_q;

  // loop state
  logic signed [17:0] verr_prev1_q, verr_prev2_q;
  logic [31:0]        vloop_out_prev_q;
  logic signed [12:0] ierr_prev_q;
  logic signed [31:0] integral_q;
  logic [15:0]        buck_duty_held_q, boost_duty_held_q;

  // working registers
  logic signed [12:0] ierr_q;
  logic signed [17:0] vout_q;
  logic signed [33:0] iloop_q;
  logic [15:0]        vref_q;
  logic               cc_q;
  logic signed [17:0] verr_q;
  logic [31:0]        acc_q;

  // output register
  logic        out_valid_q;
  logic [15:0] buck_cmp_q, boost_cmp_q;
  logic [14:0] adc_cmp_q;
  logic        cc_out_q;

  // shared multiplier
  logic                                mul_en;
  logic signed [MUL_A_W-1:0]           mul_a;
  logic signed [MUL_B_W-1:0]           mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0]   mul_p;
  logic                                use_buck;

  assign use_buck = (mode_q == MODE_BUCK);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_MULV: begin
        mul_a = signed'({{(MUL_A_W-12){1'b0}}, vs_q});
        mul_b = signed'({{(MUL_B_W-16){1'b0}}, cal_gain_q});
      end
      S_MAC0: begin
        mul_a = verr_q;
        mul_b = use_buck ? COEF_BUCK[0] : COEF_BOOST[0];
      end
      S_MAC1: begin
        mul_a = verr_prev1_q;
        mul_b = use_buck ? COEF_BUCK[1] : COEF_BOOST[1];
      end
      S_MAC2: begin
        mul_a = verr_prev2_q;
        mul_b = use_buck ? COEF_BUCK[2] : COEF_BOOST[2];
      end
      default: mul_en = 1'b0;
    endcase
  end

  bbcv_mul #(
    .AW (MUL_A_W),
    .BW (MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // calibration and current loop terms
  logic signed [17:0] vout_d;
  logic signed [33:0] ierr_x, ierr_prev_x, integral_x, integ_d, iloop_d;
  logic [31:0]        integral_d;

  always_comb begin
    vout_d      = signed'({2'b00, mul_p[27:12]}) + {{5{cal_offset_q[12]}}, cal_offset_q};
    ierr_x      = {{21{ierr_q[12]}}, ierr_q};
    ierr_prev_x = {{21{ierr_prev_q[12]}}, ierr_prev_q};
    integral_x  = {{2{integral_q[31]}}, integral_q};
    iloop_d     = integral_x + (ierr_x <<< 3) - ierr_x - ierr_prev_x;
    integ_d     = integral_x + (ierr_x <<< 1) + ierr_x;
    if (integ_d > signed'({18'd0, INTEGRAL_LIMIT})) begin
      integral_d = {16'd0, INTEGRAL_LIMIT};
    end else begin
      integral_d = integ_d[31:0];
    end
  end

  // reference limit and CV/CC selection
  logic signed [35:0] vref_sum;
  logic [15:0]        limit;
  logic               below_half;
  logic [15:0]        vref_d;
  logic               cc_d;

  always_comb begin
    below_half = ss_q && (vout_q < signed'({3'b000, vout_set_ref_q[15:1]}));
    limit      = below_half ? vout_softstart_ref_q : vout_set_ref_q;
    vref_sum   = signed'({20'd0, vout_set_ref_q}) + {{2{iloop_q[33]}}, iloop_q};
    cc_d       = 1'b1;
    vref_d     = vref_sum[15:0];
    if (vref_sum > signed'({20'd0, limit})) begin
      vref_d = limit;
      cc_d   = 1'b0;
    end else if (vref_sum < 0) begin
      vref_d = '0;
    end
  end

  logic [18:0] verr_d;
  assign verr_d = {3'b000, vref_q} - {vout_q[17], vout_q};

  // duty from compensator output: (u >>> 8) * 3, then max, then min clamp
  function automatic logic [15:0] clamp_duty(input logic [31:0] u,
                                             input logic [15:0] maxd,
                                             input logic [15:0] mind);
    logic signed [26:0] sh;
    logic signed [26:0] d;
    sh = {{3{u[31]}}, u[31:8]};
    d  = (sh <<< 1) + sh;
    if (d > signed'({11'd0, maxd})) begin
      d = signed'({11'd0, maxd});
    end
    if (d < signed'({11'd0, mind})) begin
      d = signed'({11'd0, mind});
    end
    return d[15:0];
  endfunction

  logic [15:0] buck_clamped, boost_clamped;
  assign buck_clamped  = clamp_duty(acc_q, buck_max_duty_q, MIN_BUCK_DUTY);
  assign boost_clamped = clamp_duty(acc_q, boost_max_duty_q, BOOST_DUTY_FLOOR);

  // buck duty for this step; PWM off forces the floor
  logic [15:0] buck_duty_held_d;
  always_comb begin
    unique case (mode_q)
      MODE_IDLE:  buck_duty_held_d = buck_duty_held_q;
      MODE_BUCK:  buck_duty_held_d = buck_clamped;
      MODE_BOOST: buck_duty_held_d = BUCK_FIXED_DUTY;
      default:    buck_duty_held_d = BUCK_MIX_DUTY;
    endcase
    if (!pwm_en_q) begin
      buck_duty_held_d = MIN_BUCK_DUTY;
    end
  end

  logic [15:0] buck_cmp_d;
  assign buck_cmp_d = (pwm_period_q > buck_duty_held_q) ?
                      (pwm_period_q - buck_duty_held_q) : 16'd0;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      vout_set_ref_q       <= '0;
      vout_softstart_ref_q <= '0;
      iout_target_q        <= '0;
      buck_max_duty_q      <= RST_BUCK_MAX_DUTY;
      boost_max_duty_q     <= RST_BOOST_MAX_DUTY;
      cal_gain_q           <= RST_CAL_GAIN;
      cal_offset_q         <= '0;
      pwm_period_q         <= RST_PWM_PERIOD;
      vs_q                 <= '0;
      is_q                 <= '0;
      ss_q                 <= 1'b0;
      mchg_q               <= 1'b0;
      pwm_en_q             <= 1'b0;
      mode_q               <= MODE_IDLE;
      verr_prev1_q         <= '0;
      verr_prev2_q         <= '0;
      vloop_out_prev_q     <= '0;
      ierr_prev_q          <= '0;
      integral_q           <= '0;
      buck_duty_held_q     <= '0;
      boost_duty_held_q    <= '0;
      ierr_q               <= '0;
      vout_q               <= '0;
      iloop_q              <= '0;
      vref_q               <= '0;
      cc_q                 <= 1'b1;
      verr_q               <= '0;
      acc_q                <= '0;
      out_valid_q          <= 1'b0;
      buck_cmp_q           <= '0;
      boost_cmp_q          <= '0;
      adc_cmp_q            <= '0;
      cc_out_q             <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VOUT_SET_REF:       vout_set_ref_q       <= cfg_data_i;
          CFG_VOUT_SOFTSTART_REF: vout_softstart_ref_q <= cfg_data_i;
          CFG_IOUT_TARGET:        iout_target_q        <= cfg_data_i[11:0];
          CFG_BUCK_MAX_DUTY:      buck_max_duty_q      <= cfg_data_i;
          CFG_BOOST_MAX_DUTY:     boost_max_duty_q     <= cfg_data_i;
          CFG_CAL_GAIN:           cal_gain_q           <= cfg_data_i;
          CFG_CAL_OFFSET:         cal_offset_q         <= signed'(cfg_data_i[12:0]);
          CFG_PWM_PERIOD:         pwm_period_q         <= cfg_data_i;
          default: ;
        endcase
      end

      // raise on a finished request, drop once taken downstream
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vs_q     <= vout_sample_i;
            is_q     <= iout_sample_i;
            ss_q     <= soft_start_i;
            mode_q   <= converter_mode_i;
            mchg_q   <= mode_change_i;
            pwm_en_q <= pwm_enable_i;
            state_q  <= S_MULV;
          end
        end
        S_MULV: begin
          ierr_q  <= signed'({1'b0, iout_target_q}) - signed'({1'b0, is_q});
          state_q <= S_VCAL;
        end
        S_VCAL: begin
          vout_q     <= vout_d;
          iloop_q    <= iloop_d;
          integral_q <= mchg_q ? 32'sd0 : signed'(integral_d);
          state_q    <= S_LIM;
        end
        S_LIM: begin
          vref_q  <= vref_d;
          cc_q    <= cc_d;
          state_q <= S_ERR;
        end
        S_ERR: begin
          verr_q  <= signed'(verr_d[17:0]);
          state_q <= S_MAC0;
        end
        S_MAC0: begin
          acc_q   <= mchg_q ? 32'd0 : vloop_out_prev_q;
          state_q <= S_MAC1;
        end
        S_MAC1: begin
          acc_q   <= acc_q + mul_p[31:0];
          state_q <= S_MAC2;
        end
        S_MAC2: begin
          acc_q   <= acc_q + mul_p[31:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_q + mul_p[31:0];
          state_q <= S_DUTY;
        end
        S_DUTY: begin
          if (mode_q == MODE_IDLE) begin
            // clear compensator history; boost duty held, buck duty held unless PWM is off
            verr_prev1_q     <= '0;
            verr_prev2_q     <= '0;
            vloop_out_prev_q <= '0;
          end else begin
            verr_prev2_q     <= verr_prev1_q;
            verr_prev1_q     <= verr_q;
            vloop_out_prev_q <= acc_q;
          end
          unique case (mode_q)
            MODE_IDLE: ;
            MODE_BUCK: begin
              boost_duty_held_q <= BOOST_FIXED_DUTY;
            end
            MODE_BOOST: begin
              boost_duty_held_q <= boost_clamped;
            end
            default: begin
              ierr_prev_q       <= ierr_q;
              boost_duty_held_q <= boost_clamped;
            end
          endcase
          buck_duty_held_q <= buck_duty_held_d;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            buck_cmp_q  <= buck_cmp_d;
            adc_cmp_q   <= buck_cmp_d[15:1];
            boost_cmp_q <= boost_duty_held_q;
            cc_out_q    <= cc_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign buck_compare_o        = buck_cmp_q;
  assign adc_trigger_compare_o = adc_cmp_q;
  assign boost_compare_o       = boost_cmp_q;
  assign constant_current_o    = cc_out_q;

endmodule

// File: dv/tb_buck_boost_cv_cc_loop_unit.sv
// Self-checking bench for buck_boost_cv_cc_loop_unit: a directed table, then random
// phases over several register settings and handshake idling profiles, each result
// checked by a CV/CC model or a fixed row. Depends on bbcv_pkg and the unit RTL.
module tb_buck_boost_cv_cc_loop_unit;
  import bbcv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 95;

  // Duty limits and loop gains for the local model
  localparam logic [15:0] DUTY_FLOOR_BUCK    = 16'd1360;
  localparam logic [15:0] DUTY_FLOOR_BOOST   = 16'd1360;
  localparam logic [15:0] BUCK_DUTY_BOOSTING = 16'd25568;
  localparam logic [15:0] BUCK_DUTY_MIXED    = 16'd21760;
  localparam logic [15:0] BOOST_DUTY_BUCKING = 16'd1632;
  localparam longint      INTEG_CEIL         = 4095;
  localparam longint      I_KP               = 6;
  localparam longint      I_KI               = 3;
  localparam longint      I_KD               = 1;
  localparam longint      BUCK_TAPS [3]      = '{5271, -10363, 5093};
  localparam longint      BOOST_TAPS [3]     = '{8044, -15813, 7772};

  typedef struct packed {
    logic [11:0] vout_sample;
    logic [11:0] iout_sample;
    logic        soft_start;
    logic [1:0]  converter_mode;
    logic        mode_change;
    logic        pwm_enable;
  } tick_t;

  typedef struct packed {
    logic [15:0] buck_compare;
    logic [14:0] adc_trigger_compare;
    logic [15:0] boost_compare;
    logic        constant_current;
  } compare_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] vout_set_ref;
    logic [CFG_DATA_W-1:0] vout_softstart_ref;
    logic [CFG_DATA_W-1:0] iout_target;
    logic [CFG_DATA_W-1:0] buck_max_duty;
    logic [CFG_DATA_W-1:0] boost_max_duty;
    logic [CFG_DATA_W-1:0] cal_gain;
    logic [CFG_DATA_W-1:0] cal_offset;
    logic [CFG_DATA_W-1:0] pwm_period;
  } loop_cfg_t;

  typedef enum logic [1:0] {ROW_TICK, ROW_FIXED, ROW_REGS} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  cfg_sel;
    tick_t       tick;
    compare_t    fixed;
  } row_t;

  localparam loop_cfg_t DIRECTED_CFG [3] = '{
    '{16'd3000, 16'd1000, 16'd2000, 16'd20000, 16'd20000, 16'd4096, 16'd0, 16'd27200},
    // ceilings below the floors, negative offset, zero period
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd100, 16'hFFFF, 16'hF000, 16'd0},
    '{16'd40000, 16'd100, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd0, 16'h0FFF, 16'hFFFF}
  };

  localparam int unsigned N_ROWS = 26;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_FIXED, 2'd0, '{12'd0, 12'd0, 1'b0, MODE_IDLE, 1'b0, 1'b1},
      '{16'd27200, 15'd13600, 16'd0, 1'b1}},
    '{ROW_FIXED, 2'd0, '{12'd0, 12'd0, 1'b0, MODE_IDLE, 1'b0, 1'b0},
      '{16'd25840, 15'd12920, 16'd0, 1'b1}},
    '{ROW_FIXED, 2'd0, '{12'd0, 12'd0, 1'b0, MODE_BUCK, 1'b1, 1'b1},
      '{16'd25840, 15'd12920, 16'd1632, 1'b1}},
    '{ROW_FIXED, 2'd0, '{12'd4095, 12'd4095, 1'b0, MODE_BOOST, 1'b0, 1'b1},
      '{16'd1632, 15'd816, 16'd1360, 1'b1}},
    '{ROW_REGS, 2'd0, '0, '0},
    '{ROW_TICK, 2'd0, '{12'd100, 12'd0, 1'b1, MODE_BUCK, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2000, 12'd1990, 1'b1, MODE_BUCK, 1'b0, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2900, 12'd2000, 1'b0, MODE_BUCK, 1'b0, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2950, 12'd2000, 1'b0, MODE_BUCK, 1'b0, 1'b0}, '0},
    '{ROW_TICK, 2'd0, '{12'd3000, 12'd2010, 1'b0, MODE_BOOST, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2990, 12'd1995, 1'b0, MODE_BOOST, 1'b0, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd3010, 12'd2005, 1'b0, MODE_MIX, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2995, 12'd2050, 1'b0, MODE_MIX, 1'b0, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd4095, 12'd4095, 1'b0, MODE_MIX, 1'b0, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd0, 12'd0, 1'b0, MODE_IDLE, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd0, 12'd0, 1'b0, MODE_BUCK, 1'b1, 1'b1}, '0},
    '{ROW_REGS, 2'd1, '0, '0},
    '{ROW_TICK, 2'd0, '{12'd4095, 12'd0, 1'b0, MODE_BUCK, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd0, 12'd4095, 1'b0, MODE_BOOST, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd0, 12'd0, 1'b1, MODE_MIX, 1'b0, 1'b0}, '0},
    '{ROW_TICK, 2'd0, '{12'd4095, 12'd4095, 1'b0, MODE_MIX, 1'b0, 1'b1}, '0},
    '{ROW_REGS, 2'd2, '0, '0},
    '{ROW_TICK, 2'd0, '{12'd4095, 12'd4095, 1'b1, MODE_BUCK, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd2048, 12'd1, 1'b0, MODE_BOOST, 1'b1, 1'b1}, '0},
    '{ROW_TICK, 2'd0, '{12'd1, 12'd2048, 1'b0, MODE_MIX, 1'b0, 1'b0}, '0},
    '{ROW_TICK, 2'd0, '{12'd4095, 12'd4095, 1'b1, MODE_IDLE, 1'b0, 1'b1}, '0}
  };

  logic                  clk_i;
  logic                  rst_ni                = 1'b0;
  logic                  cfg_we_i              = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i             = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i            = '0;
  logic                  in_valid_i            = 1'b0;
  logic                  in_stall_o;
  logic [11:0]           vout_sample_i         = '0;
  logic [11:0]           iout_sample_i         = '0;
  logic                  soft_start_i          = 1'b0;
  logic [1:0]            converter_mode_i      = MODE_IDLE;
  logic                  mode_change_i         = 1'b0;
  logic                  pwm_enable_i          = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i           = 1'b0;
  logic [15:0]           buck_compare_o;
  logic [14:0]           adc_trigger_compare_o;
  logic [15:0]           boost_compare_o;
  logic                  constant_current_o;

  // Register mirror, at reset values
  logic [15:0]        reg_vset      = 16'd0;
  logic [15:0]        reg_vss       = 16'd0;
  logic [11:0]        reg_iref      = 12'd0;
  logic [15:0]        reg_buck_max  = 16'd25568;
  logic [15:0]        reg_boost_max = 16'd25568;
  logic [15:0]        reg_gain      = 16'd4096;
  logic signed [12:0] reg_offset    = 13'sd0;
  logic [15:0]        reg_period    = 16'd27200;

  // Loop history
  int          verr_z1     = 0;
  int          verr_z2     = 0;
  int          comp_out    = 0;
  int          ierr_last   = 0;
  int          integral    = 0;
  logic [15:0] buck_held   = '0;
  logic [15:0] boost_held  = '0;

  compare_t    pending_compares [$];
  int unsigned fault_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Random walk state for well-formed tick sequences
  logic [1:0]  walk_mode = MODE_IDLE;
  int          vs_walk   = 0;
  int          is_walk   = 0;
  int unsigned ss_left   = 0;

  buck_boost_cv_cc_loop_unit u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .vout_sample_i         (vout_sample_i),
    .iout_sample_i         (iout_sample_i),
    .soft_start_i          (soft_start_i),
    .converter_mode_i      (converter_mode_i),
    .mode_change_i         (mode_change_i),
    .pwm_enable_i          (pwm_enable_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .buck_compare_o        (buck_compare_o),
    .adc_trigger_compare_o (adc_trigger_compare_o),
    .boost_compare_o       (boost_compare_o),
    .constant_current_o    (constant_current_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_VOUT_SET_REF:       reg_vset = data;
      CFG_VOUT_SOFTSTART_REF: reg_vss = data;
      CFG_IOUT_TARGET:        reg_iref = data[11:0];
      CFG_BUCK_MAX_DUTY:      reg_buck_max = data;
      CFG_BOOST_MAX_DUTY:     reg_boost_max = data;
      CFG_CAL_GAIN:           reg_gain = data;
      CFG_CAL_OFFSET:         reg_offset = data[12:0];
      CFG_PWM_PERIOD:         reg_period = data;
    endcase
  endfunction

  function automatic int run_2p2z(longint c0, longint c1, longint c2, int e0);
    longint acc;
    acc = longint'(comp_out) + longint'(e0) * c0 + longint'(verr_z1) * c1
        + longint'(verr_z2) * c2;
    verr_z2  = verr_z1;
    verr_z1  = e0;
    comp_out = int'(acc);
    return comp_out;
  endfunction

  function automatic logic [15:0] clamp_duty(int u, logic [15:0] duty_hi, logic [15:0] duty_lo);
    longint d;
    d = (longint'(u) >>> 8) * 3;
    if (d > longint'(duty_hi)) d = longint'(duty_hi);
    // floor applied last, so it wins over a lower ceiling
    if (d < longint'(duty_lo)) d = longint'(duty_lo);
    return d[15:0];
  endfunction

  // One sample tick of the cascaded loop; returns the compare values it yields
  function automatic compare_t advance_loop(tick_t t);
    compare_t    r;
    longint      vcal, ierr, iloop, integ, vlim, vref;
    logic        cc;
    int          verr, u;
    logic [15:0] gap;
    vcal  = ((longint'(t.vout_sample) * longint'(reg_gain)) >>> 12) + longint'(reg_offset);
    ierr  = longint'(reg_iref) - longint'(t.iout_sample);
    iloop = longint'(integral) + ierr * I_KP + (ierr - longint'(ierr_last)) * I_KD;
    integ = longint'(integral) + ierr * I_KI;
    if (integ > INTEG_CEIL) integ = INTEG_CEIL;
    integral = int'(integ);

    if (t.soft_start && vcal < longint'(reg_vset >> 1)) vlim = longint'(reg_vss);
    else vlim = longint'(reg_vset);
    vref = longint'(reg_vset) + iloop;
    cc   = 1'b1;
    if (vref > vlim) begin
      vref = vlim;
      cc   = 1'b0;
    end
    // zero clamp leaves the CC/CV flag alone
    if (vref < 0) vref = 0;
    verr = int'(vref - vcal);

    if (t.mode_change) begin
      comp_out = 0;
      integral = 0;
    end

    case (t.converter_mode)
      MODE_IDLE: begin
        verr_z1  = 0;
        verr_z2  = 0;
        comp_out = 0;
      end
      MODE_BUCK: begin
        u          = run_2p2z(BUCK_TAPS[0], BUCK_TAPS[1], BUCK_TAPS[2], verr);
        boost_held = BOOST_DUTY_BUCKING;
        buck_held  = clamp_duty(u, reg_buck_max, DUTY_FLOOR_BUCK);
      end
      MODE_BOOST: begin
        u          = run_2p2z(BOOST_TAPS[0], BOOST_TAPS[1], BOOST_TAPS[2], verr);
        buck_held  = BUCK_DUTY_BOOSTING;
        boost_held = clamp_duty(u, reg_boost_max, DUTY_FLOOR_BOOST);
      end
      MODE_MIX: begin
        u          = run_2p2z(BOOST_TAPS[0], BOOST_TAPS[1], BOOST_TAPS[2], verr);
        ierr_last  = int'(ierr);
        buck_held  = BUCK_DUTY_MIXED;
        boost_held = clamp_duty(u, reg_boost_max, DUTY_FLOOR_BOOST);
      end
    endcase

    if (!t.pwm_enable) buck_held = DUTY_FLOOR_BUCK;

    gap = (reg_period > buck_held) ? reg_period - buck_held : 16'd0;
    r.buck_compare        = gap;
    r.adc_trigger_compare = gap[15:1];
    r.boost_compare       = boost_held;
    r.constant_current    = cc;
    return r;
  endfunction

  function automatic int wander(int v);
    if ($urandom_range(19) == 0) return int'($urandom_range(4095));
    v = v + int'($urandom_range(80)) - 40;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Mostly well-formed sequences: mode held, a mode-change pulse on each switch,
  // soft start after some switches, slowly moving samples; a few ticks pure noise.
  function automatic tick_t next_tick();
    tick_t      t;
    logic [1:0] prev_mode;
    if ($urandom_range(99) < 8) return tick_t'(29'($urandom));
    t.mode_change = 1'b0;
    if ($urandom_range(99) < 5) begin
      prev_mode = walk_mode;
      while (walk_mode == prev_mode) walk_mode = 2'($urandom);
      t.mode_change = 1'b1;
      if ($urandom_range(2) == 0) ss_left = $urandom_range(4, 40);
    end
    t.converter_mode = walk_mode;
    t.soft_start     = (ss_left != 0);
    if (ss_left != 0) ss_left--;
    t.pwm_enable  = ($urandom_range(15) != 0);
    vs_walk       = wander(vs_walk);
    is_walk       = wander(is_walk);
    t.vout_sample = 12'(vs_walk);
    t.iout_sample = 12'(is_walk);
    return t;
  endfunction

  function automatic loop_cfg_t pick_regs(int unsigned phase);
    loop_cfg_t c;
    if (phase == 0) begin
      c            = '0;
      c.cal_offset = 16'h1000;
    end else if (phase == 1) begin
      c            = '1;
      c.cal_offset = 16'hEFFF;
    end else begin
      c = loop_cfg_t'({$urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(3) != 0) begin
        c.vout_set_ref       = 16'($urandom_range(1000, 6000));
        c.vout_softstart_ref = 16'($urandom_range(0, c.vout_set_ref));
        c.buck_max_duty      = 16'($urandom_range(15000, 27000));
        c.boost_max_duty     = 16'($urandom_range(15000, 27000));
        c.cal_gain           = 16'($urandom_range(3500, 4700));
        c.pwm_period         = 16'($urandom_range(20000, 40000));
      end
    end
    return c;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // Hold off requests until every pending result is back and the pipe is empty
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_compares.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    mirror_reg(idx, data);
  endtask

  task automatic program_regs(loop_cfg_t c);
    drain_requests();
    write_reg(CFG_VOUT_SET_REF, c.vout_set_ref);
    write_reg(CFG_VOUT_SOFTSTART_REF, c.vout_softstart_ref);
    write_reg(CFG_IOUT_TARGET, c.iout_target);
    write_reg(CFG_BUCK_MAX_DUTY, c.buck_max_duty);
    write_reg(CFG_BOOST_MAX_DUTY, c.boost_max_duty);
    write_reg(CFG_CAL_GAIN, c.cal_gain);
    write_reg(CFG_CAL_OFFSET, c.cal_offset);
    write_reg(CFG_PWM_PERIOD, c.pwm_period);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(tick_t t, logic use_fixed, compare_t fixed);
    int unsigned gap;
    compare_t    want;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    vout_sample_i    <= t.vout_sample;
    iout_sample_i    <= t.iout_sample;
    soft_start_i     <= t.soft_start;
    converter_mode_i <= t.converter_mode;
    mode_change_i    <= t.mode_change;
    pwm_enable_i     <= t.pwm_enable;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    want = advance_loop(t);
    pending_compares.push_back(use_fixed ? fixed : want);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : compare_results
    compare_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_compares.size() == 0) begin
        $error("result with no request pending");
        fault_count++;
      end else begin
        want = pending_compares.pop_front();
        check_field("buck_compare", want.buck_compare, buck_compare_o);
        check_field("adc_trigger_compare", 16'(want.adc_trigger_compare),
                    16'(adc_trigger_compare_o));
        check_field("boost_compare", want.boost_compare, boost_compare_o);
        check_field("constant_current", 16'(want.constant_current),
                    16'(constant_current_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    tick_t       t;
    loop_cfg_t   c;
    int unsigned phase, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REGS) program_regs(DIRECTED_CFG[DIRECTED[i].cfg_sel]);
      else send_tick(DIRECTED[i].tick, DIRECTED[i].kind == ROW_FIXED, DIRECTED[i].fixed);
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      c = pick_regs(phase);
      program_regs(c);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      is_walk = int'(c.iout_target[11:0]);
      vs_walk = int'($urandom_range(4095));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        t = next_tick();
        send_tick(t, 1'b0, '0);
      end
    end

    drain_requests();
    if (fault_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
